// ----- sv/tbot_pkg.sv -----
// Shared constants for the triangle versus box overlap test unit.
package tbot_pkg;

    // Default coordinate width of one packed x, y or z value.
    localparam int COORD_BITS_DEF = 21;

    // Width of one packed vector field and of the input stream data.
    localparam int FIELD_BITS = 63;
    localparam int NUM_FIELDS = 5;
    localparam int IN_DATA_BITS = 320;
    localparam int OUT_DATA_BITS = 8;

    // Field order on the input stream.
    localparam int FLD_CENTER = 0;
    localparam int FLD_HALF = 1;
    localparam int FLD_VA = 2;
    localparam int FLD_VB = 3;
    localparam int FLD_VC = 4;

    // Edge-cross-box-axis tests: edge, box axis, the two axis components
    // used and the two vertices projected.
    localparam int NUM_EDGE_TESTS = 9;
    localparam logic [1:0] ET_EDGE [NUM_EDGE_TESTS] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] ET_U [NUM_EDGE_TESTS] = '{
        2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0};
    localparam logic [1:0] ET_W [NUM_EDGE_TESTS] = '{
        2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1};
    localparam logic [1:0] ET_VA [NUM_EDGE_TESTS] = '{
        2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1};
    localparam logic [1:0] ET_VB [NUM_EDGE_TESTS] = '{
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2};

    // Pipeline depth, input register to output register.
    localparam int NUM_STAGES = 7;

endpackage

// ----- sv/triangle_box_overlap_test_unit.sv -----
// Triangle versus axis-aligned box overlap test, separating-axis method, pipelined.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata): one transaction carries a box
//   (center, half sizes) and a triangle (three vertices), each a 63-bit field
//   of three packed COORD_BITS-bit two's-complement coordinates, x lowest.
//   Output stream (m_tvalid/m_tready/m_tdata): one transaction per input,
//   bit 0 is the overlap flag (touching counts as overlap).
//   Pipeline: 7 register stages; the accepting edge loads stage 1 and m_tvalid
//   rises when the transaction reaches stage 7.
//   Throughput: one transaction per cycle unless the output stalls; the seven
//   register stages all advance together, so the figure is set by the
//   one-stage-per-cycle pipeline with a single shared advance enable.
//   Stages: vertex offsets, edges, products, differences, separation
//   compares and split normal products, partial sums, final signs.
//   The plane test sign (exact dot product) is split into high and
//   low partial products so no multiplier exceeds 24 by 23 bits at the default width.
//   Reset: all stage valid bits clear; no transaction is in flight.
//   Stall: when the output holds a result and m_tready is low, the whole
//   pipeline freezes and s_tready drops; nothing is lost or repeated.
module triangle_box_overlap_test_unit #(
    parameter int COORD_BITS = tbot_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [62:0] box_center, [125:63] box_half, [188:126] vertex_a,
    // [251:189] vertex_b, [314:252] vertex_c, [319:315] zero
    input  logic [tbot_pkg::IN_DATA_BITS-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] overlap, [7:1] zero
    output logic [tbot_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    localparam int CB = COORD_BITS;
    localparam int VW = CB + 1;            // vertex minus center
    localparam int EW = CB + 2;            // edge
    localparam int PW = EW + VW;           // edge times vertex
    localparam int RW = EW + CB;           // |edge| times half size
    localparam int AW = PW + 1;            // projection / radius sums
    localparam int NW = 2 * EW + 1;        // normal component
    localparam int MW = CB + 2;            // +-half minus vertex
    localparam int LOW = NW / 2;           // low split of normal
    localparam int HIW = NW - LOW;
    localparam int LPW = LOW + 1 + MW;
    localparam int HPW = HIW + MW;
    localparam int LSW = LPW + 2;
    localparam int HSW = HPW + 2;
    localparam int TW = NW + MW + 3;
    localparam int NT = tbot_pkg::NUM_EDGE_TESTS;
    localparam int NS = tbot_pkg::NUM_STAGES;
    localparam int FB = tbot_pkg::FIELD_BITS;

    logic [NS-1:0] vld_reg;
    logic          en;

    // stage 1
    logic signed [VW-1:0] v1_reg [3][3], v1_next [3][3];
    logic signed [CB-1:0] h1_reg [3], h1_next [3];
    // stage 2
    logic signed [EW-1:0] e2_reg [3][3], e2_next [3][3];
    logic signed [VW-1:0] v2_reg [3][3];
    logic signed [CB-1:0] h2_reg [3];
    // stage 3
    logic signed [PW-1:0] pp3_reg [NT][2][2], pp3_next [NT][2][2];
    logic signed [RW-1:0] rp3_reg [NT][2], rp3_next [NT][2];
    logic signed [2*EW-1:0] np3_reg [3][2], np3_next [3][2];
    logic signed [MW-1:0] mpos3_reg [3], mpos3_next [3];
    logic signed [MW-1:0] mneg3_reg [3], mneg3_next [3];
    logic                 sep3_reg, sep3_next;
    // stage 4
    logic signed [AW-1:0] pa4_reg [NT], pa4_next [NT];
    logic signed [AW-1:0] pb4_reg [NT], pb4_next [NT];
    logic signed [AW-1:0] rad4_reg [NT], rad4_next [NT];
    logic signed [NW-1:0] n4_reg [3], n4_next [3];
    logic signed [MW-1:0] mpos4_reg [3], mneg4_reg [3];
    logic                 sep4_reg;
    // stage 5: [0] near corner, [1] far corner
    logic signed [LPW-1:0] lp5_reg [2][3], lp5_next [2][3];
    logic signed [HPW-1:0] hp5_reg [2][3], hp5_next [2][3];
    logic                  sep5_reg, sep5_next;
    // stage 6
    logic signed [LSW-1:0] ls6_reg [2], ls6_next [2];
    logic signed [HSW-1:0] hs6_reg [2], hs6_next [2];
    logic                  sep6_reg;
    // stage 7 (output)
    logic overlap_reg, overlap_next;

    assign en = !vld_reg[NS-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata = {{(tbot_pkg::OUT_DATA_BITS-1){1'b0}}, overlap_reg};

    // stage 1: unpack, offset vertices by the box center
    always_comb
    begin
        logic signed [CB-1:0] c, a;
        for (int k = 0; k < 3; k++)
        begin
            c = $signed(s_tdata[tbot_pkg::FLD_CENTER*FB + k*CB +: CB]);
            h1_next[k] = $signed(s_tdata[tbot_pkg::FLD_HALF*FB + k*CB +: CB]);
            for (int j = 0; j < 3; j++)
            begin
                a = $signed(s_tdata[(tbot_pkg::FLD_VA + j)*FB + k*CB +: CB]);
                v1_next[j][k] = VW'(a) - VW'(c);
            end
        end
    end

    // stage 2: edges
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e2_next[0][k] = EW'(v1_reg[1][k]) - EW'(v1_reg[0][k]);
            e2_next[1][k] = EW'(v1_reg[2][k]) - EW'(v1_reg[1][k]);
            e2_next[2][k] = EW'(v1_reg[0][k]) - EW'(v1_reg[2][k]);
        end
    end

    // stage 3: all products, box-axis test, plane-test corner candidates
    always_comb
    begin
        logic signed [EW-1:0] eu, ew, aeu, aew;
        logic signed [VW-1:0] lo, hi;
        sep3_next = 1'b0;
        for (int t = 0; t < NT; t++)
        begin
            eu = e2_reg[tbot_pkg::ET_EDGE[t]][tbot_pkg::ET_U[t]];
            ew = e2_reg[tbot_pkg::ET_EDGE[t]][tbot_pkg::ET_W[t]];
            aeu = eu[EW-1] ? -eu : eu;
            aew = ew[EW-1] ? -ew : ew;
            pp3_next[t][0][0] = PW'(ew) * PW'(v2_reg[tbot_pkg::ET_VA[t]][tbot_pkg::ET_U[t]]);
            pp3_next[t][0][1] = PW'(eu) * PW'(v2_reg[tbot_pkg::ET_VA[t]][tbot_pkg::ET_W[t]]);
            pp3_next[t][1][0] = PW'(ew) * PW'(v2_reg[tbot_pkg::ET_VB[t]][tbot_pkg::ET_U[t]]);
            pp3_next[t][1][1] = PW'(eu) * PW'(v2_reg[tbot_pkg::ET_VB[t]][tbot_pkg::ET_W[t]]);
            rp3_next[t][0] = RW'(aew) * RW'(h2_reg[tbot_pkg::ET_U[t]]);
            rp3_next[t][1] = RW'(aeu) * RW'(h2_reg[tbot_pkg::ET_W[t]]);
        end
        for (int k = 0; k < 3; k++)
        begin
            lo = v2_reg[0][k];
            hi = v2_reg[0][k];
            for (int j = 1; j < 3; j++)
            begin
                if (v2_reg[j][k] < lo)
                    lo = v2_reg[j][k];
                if (v2_reg[j][k] > hi)
                    hi = v2_reg[j][k];
            end
            if (lo > VW'(h2_reg[k]) || hi < -VW'(h2_reg[k]))
                sep3_next = 1'b1;
            mpos3_next[k] = MW'(h2_reg[k]) - MW'(v2_reg[0][k]);
            mneg3_next[k] = -MW'(h2_reg[k]) - MW'(v2_reg[0][k]);
        end
        // normal = e0 x e1
        np3_next[0][0] = (2*EW)'(e2_reg[0][1]) * (2*EW)'(e2_reg[1][2]);
        np3_next[0][1] = (2*EW)'(e2_reg[0][2]) * (2*EW)'(e2_reg[1][1]);
        np3_next[1][0] = (2*EW)'(e2_reg[0][2]) * (2*EW)'(e2_reg[1][0]);
        np3_next[1][1] = (2*EW)'(e2_reg[0][0]) * (2*EW)'(e2_reg[1][2]);
        np3_next[2][0] = (2*EW)'(e2_reg[0][0]) * (2*EW)'(e2_reg[1][1]);
        np3_next[2][1] = (2*EW)'(e2_reg[0][1]) * (2*EW)'(e2_reg[1][0]);
    end

    // stage 4: projections, radii, normal
    always_comb
    begin
        for (int t = 0; t < NT; t++)
        begin
            pa4_next[t] = AW'(pp3_reg[t][0][0]) - AW'(pp3_reg[t][0][1]);
            pb4_next[t] = AW'(pp3_reg[t][1][0]) - AW'(pp3_reg[t][1][1]);
            rad4_next[t] = AW'(rp3_reg[t][0]) + AW'(rp3_reg[t][1]);
        end
        for (int q = 0; q < 3; q++)
            n4_next[q] = NW'(np3_reg[q][0]) - NW'(np3_reg[q][1]);
    end

    // stage 5: edge-axis compares, split normal dot products
    always_comb
    begin
        logic signed [AW-1:0] lo, hi;
        logic signed [MW-1:0] mn, mf;
        logic signed [LOW:0]  nl;
        logic signed [HIW-1:0] nh;
        sep5_next = sep4_reg;
        for (int t = 0; t < NT; t++)
        begin
            lo = (pa4_reg[t] < pb4_reg[t]) ? pa4_reg[t] : pb4_reg[t];
            hi = (pa4_reg[t] < pb4_reg[t]) ? pb4_reg[t] : pa4_reg[t];
            if (lo > rad4_reg[t] || hi < -rad4_reg[t])
                sep5_next = 1'b1;
        end
        for (int q = 0; q < 3; q++)
        begin
            if (n4_reg[q] > 0)
            begin
                mn = mneg4_reg[q];
                mf = mpos4_reg[q];
            end
            else
            begin
                mn = mpos4_reg[q];
                mf = mneg4_reg[q];
            end
            nl = $signed({1'b0, n4_reg[q][LOW-1:0]});
            nh = $signed(n4_reg[q][NW-1:LOW]);
            lp5_next[0][q] = LPW'(nl) * LPW'(mn);
            lp5_next[1][q] = LPW'(nl) * LPW'(mf);
            hp5_next[0][q] = HPW'(nh) * HPW'(mn);
            hp5_next[1][q] = HPW'(nh) * HPW'(mf);
        end
    end

    // stage 6: partial sums
    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            ls6_next[s] = LSW'(lp5_reg[s][0]) + LSW'(lp5_reg[s][1]) + LSW'(lp5_reg[s][2]);
            hs6_next[s] = HSW'(hp5_reg[s][0]) + HSW'(hp5_reg[s][1]) + HSW'(hp5_reg[s][2]);
        end
    end

    // stage 7: recombine, plane test, final decision
    always_comb
    begin
        logic signed [TW-1:0] tn, tf;
        tn = (TW'(hs6_reg[0]) <<< LOW) + TW'(ls6_reg[0]);
        tf = (TW'(hs6_reg[1]) <<< LOW) + TW'(ls6_reg[1]);
        overlap_next = !sep6_reg && !(tn > 0) && !tf[TW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg <= v1_next;
            h1_reg <= h1_next;
            e2_reg <= e2_next;
            v2_reg <= v1_reg;
            h2_reg <= h1_reg;
            pp3_reg <= pp3_next;
            rp3_reg <= rp3_next;
            np3_reg <= np3_next;
            mpos3_reg <= mpos3_next;
            mneg3_reg <= mneg3_next;
            sep3_reg <= sep3_next;
            pa4_reg <= pa4_next;
            pb4_reg <= pb4_next;
            rad4_reg <= rad4_next;
            n4_reg <= n4_next;
            mpos4_reg <= mpos3_reg;
            mneg4_reg <= mneg3_reg;
            sep4_reg <= sep3_reg;
            lp5_reg <= lp5_next;
            hp5_reg <= hp5_next;
            sep5_reg <= sep5_next;
            ls6_reg <= ls6_next;
            hs6_reg <= hs6_next;
            sep6_reg <= sep5_reg;
            overlap_reg <= overlap_next;
        end
    end

`ifndef SYNTHESIS
    // accepted transaction enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted transaction missing from stage 1");

    // a stalled output freezes every stage
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

    // a separating axis found early always forces a miss
    a_sep: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-2] && sep6_reg && en |=> !m_tdata[0])
        else $error("overlap reported after separating axis");
`endif

endmodule
